/* rtl/etq_pkg.sv */
// Shared types, constants and the arctangent table for the Euler to quaternion converter.
package etq_pkg;

    // Field widths
    localparam int ANGLE_BITS   = 16;
    localparam int RESULT_BITS  = 16;
    localparam int ANGLE_FRAC   = ANGLE_BITS - 3;

    // Stream word widths, rounded up to whole bytes
    localparam int S_TDATA_BITS = ((3 * ANGLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((4 * RESULT_BITS + 7) / 8) * 8;

    // CORDIC datapath
    localparam int CORDIC_STEPS = 30;
    localparam int Z_BITS       = 33;
    localparam int XY_BITS      = 34;
    localparam int TRIG_BITS    = 32;
    localparam int Z_SHIFT      = 32 - ANGLE_BITS;

    // Product and result datapath
    localparam int MUL_BITS     = 2 * TRIG_BITS;
    localparam int PAIR_BITS    = 34;
    localparam int TRIPLE_BITS  = PAIR_BITS + TRIG_BITS;
    localparam int SUM_BITS     = TRIPLE_BITS + 1;
    localparam int RES_SHIFT    = 62 - RESULT_BITS;
    localparam int RND_BITS     = SUM_BITS - RES_SHIFT;

    // Pipeline: angle register, one stage per iteration, then pair, triple,
    // sum, round and the output register
    localparam int PIPE_STAGES  = CORDIC_STEPS + 6;

    typedef logic signed [ANGLE_BITS-1:0]  angle_t;
    typedef logic signed [RESULT_BITS-1:0] result_t;
    typedef logic signed [Z_BITS-1:0]      z_t;
    typedef logic signed [XY_BITS-1:0]     xy_t;
    typedef logic signed [TRIG_BITS-1:0]   trig_t;
    typedef logic signed [MUL_BITS-1:0]    mul_t;
    typedef logic signed [PAIR_BITS-1:0]   pair_t;
    typedef logic signed [TRIPLE_BITS-1:0] triple_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic signed [RND_BITS-1:0]    rnd_t;

    // Pi, used for the input limit, rounded to the angle format
    localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
    localparam logic [63:0] PI_CODE =
        (PI_Q62 + (64'd1 << (61 - ANGLE_FRAC))) >> (62 - ANGLE_FRAC);
    localparam angle_t PI_ANGLE = angle_t'(PI_CODE);

    // CORDIC gain in Q30, applied up front
    localparam xy_t GAIN_Q30 = xy_t'(652032874);

    // Pair product rounding and final rounding offsets
    localparam mul_t PAIR_RND = mul_t'(64'd1 << 29);
    localparam sum_t RES_RND  = sum_t'(1) <<< (RES_SHIFT - 1);
    localparam rnd_t RES_LIM  = rnd_t'(1) <<< (RESULT_BITS - 2);

    // Arctangent of 2^-i in Q30
    localparam logic signed [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6, 32'sh03FEAB76,
        32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55, 32'sh003FFFEA, 32'sh001FFFFD,
        32'sh000FFFFF, 32'sh0007FFFF, 32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF,
        32'sh00007FFF, 32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
        32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F, 32'sh0000003F,
        32'sh0000001F, 32'sh0000000F, 32'sh00000008, 32'sh00000004, 32'sh00000002
    };

endpackage

/* rtl/etq_cordic.sv */
// Pipelined rotation-mode CORDIC giving the cosine and sine of half an angle.
module etq_cordic (
    input  logic           clk,
    input  logic           en,
    input  etq_pkg::angle_t angle,
    output etq_pkg::trig_t cos_out,
    output etq_pkg::trig_t sin_out
);
    import etq_pkg::*;

    angle_t angle_lim;
    z_t     z_reg [CORDIC_STEPS];
    xy_t    x_reg [CORDIC_STEPS+1];
    xy_t    y_reg [CORDIC_STEPS+1];

    // Limit the angle to plus or minus pi
    always_comb
    begin
        priority if (angle > PI_ANGLE)
            angle_lim = PI_ANGLE;
        else if (angle < -PI_ANGLE)
            angle_lim = -PI_ANGLE;
        else
            angle_lim = angle;
    end

    // Load the half angle in Q30 and the pre-scaled unit vector
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0] <= z_t'(angle_lim) <<< Z_SHIFT;
            x_reg[0] <= GAIN_Q30;
            y_reg[0] <= '0;
        end
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        xy_t x_next;
        xy_t y_next;

        always_comb
        begin
            if (!z_reg[i][Z_BITS-1])
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
            end
            else
            begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
            end
        end

        // Advance the residual angle; after the last step only its sign was needed
        if (i < CORDIC_STEPS - 1)
        begin : g_angle
            z_t z_next;

            always_comb
            begin
                if (!z_reg[i][Z_BITS-1])
                    z_next = z_reg[i] - z_t'(ATAN_Q30[i]);
                else
                    z_next = z_reg[i] + z_t'(ATAN_Q30[i]);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    z_reg[i+1] <= z_next;
            end
        end
    end

    assign cos_out = trig_t'(x_reg[CORDIC_STEPS]);
    assign sin_out = trig_t'(y_reg[CORDIC_STEPS]);

endmodule

/* rtl/euler_to_quaternion.sv */
// Top level: roll, pitch and yaw to the unit quaternion of the Z-Y-X rotation.
//
//  channel  | direction | tdata fields (lowest bit first)
//  s_axis   | in        | roll_angle, pitch_angle, yaw_angle (16 bits each)
//  m_axis   | out       | quat_w, quat_x, quat_y, quat_z (16 bits each)
//
// One word is taken per cycle while the output word is not held; m_axis_tvalid
// rises when the word reaches the last of 36 register stages, the first loaded
// at the accepting edge: the angle register, 30 CORDIC stages (one micro-rotation
// each), then the pair product, triple product, sum, rounding and output registers.
// rst_n clears only the valid bits; data registers are not reset.
// When the output word is held, the whole pipeline holds with it.
module euler_to_quaternion (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [etq_pkg::S_TDATA_BITS-1:0] s_axis_tdata,  // roll, pitch, yaw
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [etq_pkg::M_TDATA_BITS-1:0] m_axis_tdata   // w, x, y, z
);
    import etq_pkg::*;

    logic                   en;
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_next;

    angle_t roll_angle;
    angle_t pitch_angle;
    angle_t yaw_angle;

    trig_t cr, sr, cp, sp, cy, sy;

    // Pair products: cr*cp, sr*sp, sr*cp, cr*sp
    pair_t   pair_reg [4];
    trig_t   cy_reg;
    trig_t   sy_reg;
    triple_t trip_reg [8];
    sum_t    sum_reg  [4];
    rnd_t    rnd_reg  [4];
    result_t quat_reg [4];

    // Advance when the output word is empty or being taken
    assign en            = !vld_reg[PIPE_STAGES-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[PIPE_STAGES-1];

    // Unpack the input word
    assign roll_angle  = angle_t'(s_axis_tdata[ANGLE_BITS-1:0]);
    assign pitch_angle = angle_t'(s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]);
    assign yaw_angle   = angle_t'(s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]);

    etq_cordic u_roll  (.clk(clk), .en(en), .angle(roll_angle),  .cos_out(cr), .sin_out(sr));
    etq_cordic u_pitch (.clk(clk), .en(en), .angle(pitch_angle), .cos_out(cp), .sin_out(sp));
    etq_cordic u_yaw   (.clk(clk), .en(en), .angle(yaw_angle),   .cos_out(cy), .sin_out(sy));

    // Shift the valid bits along with the data
    assign vld_next = {vld_reg[PIPE_STAGES-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // Round the pair products to Q30
    function automatic pair_t mul_q30(trig_t a, trig_t b);
        mul_t m;
        m = mul_t'(a) * mul_t'(b);
        return pair_t'((m + PAIR_RND) >>> 30);
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pair_reg[0] <= mul_q30(cr, cp);
            pair_reg[1] <= mul_q30(sr, sp);
            pair_reg[2] <= mul_q30(sr, cp);
            pair_reg[3] <= mul_q30(cr, sp);
            cy_reg      <= cy;
            sy_reg      <= sy;
        end
    end

    // Form the triple products in Q60
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trip_reg[0] <= triple_t'(pair_reg[0]) * triple_t'(cy_reg);
            trip_reg[1] <= triple_t'(pair_reg[1]) * triple_t'(sy_reg);
            trip_reg[2] <= triple_t'(pair_reg[2]) * triple_t'(cy_reg);
            trip_reg[3] <= triple_t'(pair_reg[3]) * triple_t'(sy_reg);
            trip_reg[4] <= triple_t'(pair_reg[3]) * triple_t'(cy_reg);
            trip_reg[5] <= triple_t'(pair_reg[2]) * triple_t'(sy_reg);
            trip_reg[6] <= triple_t'(pair_reg[0]) * triple_t'(sy_reg);
            trip_reg[7] <= triple_t'(pair_reg[1]) * triple_t'(cy_reg);
        end
    end

    // Combine the terms of each component
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg[0] <= sum_t'(trip_reg[0]) + sum_t'(trip_reg[1]);
            sum_reg[1] <= sum_t'(trip_reg[2]) - sum_t'(trip_reg[3]);
            sum_reg[2] <= sum_t'(trip_reg[4]) + sum_t'(trip_reg[5]);
            sum_reg[3] <= sum_t'(trip_reg[6]) - sum_t'(trip_reg[7]);
        end
    end

    // Round half up to the result format, then saturate at plus or minus one
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                rnd_reg[k] <= rnd_t'((sum_reg[k] + RES_RND) >>> RES_SHIFT);
                priority if (rnd_reg[k] > RES_LIM)
                    quat_reg[k] <= result_t'(RES_LIM);
                else if (rnd_reg[k] < -RES_LIM)
                    quat_reg[k] <= result_t'(-RES_LIM);
                else
                    quat_reg[k] <= result_t'(rnd_reg[k]);
            end
        end
    end

    // Pack the output word, zero-filled to whole bytes
    assign m_axis_tdata = M_TDATA_BITS'({quat_reg[3], quat_reg[2], quat_reg[1], quat_reg[0]});

`ifndef SYNTHESIS
    // An accepted word enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted word did not enter the pipeline");

    // A held output word freezes every stage
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(vld_reg))
        else $error("pipeline moved while output was held");

    // The input side is open whenever the output is not blocked
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input refused with an empty output stage");

    // Delivered w and z components stay within plus or minus one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> quat_reg[0] <= result_t'(RES_LIM) && quat_reg[0] >= -result_t'(RES_LIM)
                       && quat_reg[3] <= result_t'(RES_LIM) && quat_reg[3] >= -result_t'(RES_LIM))
        else $error("quaternion component outside the unit range");
`endif

endmodule

/* tb/euler_to_quaternion_test.sv */
`timescale 1ns / 1ps
// Self-checking stream testbench for the Euler angle to quaternion converter.
module euler_to_quaternion_test;

    import etq_pkg::*;

    localparam int     HALF_PERIOD  = 5;
    localparam int     RESET_CYCLES = 3;
    localparam int     RAND_ITEMS   = 1750;
    localparam int     LATENCY      = 36;
    localparam int     DRAIN_CYCLES = 2 * LATENCY;
    localparam int     CYCLE_LIMIT  = 1000000;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     HOLD_AFTER   = 400;
    localparam int     MAX_REPORTS  = 30;

    // Fixed-point constants of the conversion
    localparam int     TRIG_STEPS   = 30;
    localparam longint TRIG_GAIN    = 64'sd652032874;
    localparam longint ANGLE_PI     =
        longint'((64'hC90FDAA22168C235 + (64'd1 << 48)) >> 49);
    localparam longint ONE_Q14      = 64'sd16384;
    localparam longint ARCTAN_Q30 [TRIG_STEPS] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76,
        'h01FFD55B, 'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD,
        'h000FFFFF, 'h0007FFFF, 'h0003FFFF, 'h0001FFFF, 'h0000FFFF,
        'h00007FFF, 'h00003FFF, 'h00001FFF, 'h00000FFF, 'h000007FF,
        'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F, 'h0000003F,
        'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002
    };

    typedef struct packed {
        angle_t yaw;
        angle_t pitch;
        angle_t roll;
    } euler_t;

    typedef struct {
        result_t w;
        result_t x;
        result_t y;
        result_t z;
    } quat_t;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [S_TDATA_BITS-1:0] s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_axis_tdata;

    euler_t euler_q[$];
    quat_t  quat_expected[$];
    euler_t offered;
    euler_t next_word;
    quat_t  got_quat;
    quat_t  want_quat;

    int     total_items    = 0;
    int     accepted_count = 0;
    int     results_seen   = 0;
    int     clamped_inputs = 0;
    int     error_count    = 0;
    int     cycle_count    = 0;
    int     send_gap       = 0;
    int     ready_gap      = 0;
    int     hold_left      = 0;
    int     input_stalls   = 0;
    bit     hold_done      = 1'b0;
    bit     in_accepted    = 1'b0;
    bit     in_quiet       = 1'b0;
    bit     out_quiet      = 1'b0;
    int     n;

    euler_to_quaternion dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // roll, pitch, yaw
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // w, x, y, z
    );

    always #HALF_PERIOD clk = ~clk;

    // Sine and cosine of half an angle: clamp to +/-pi, then 30 CORDIC rotations in Q30
    function automatic void half_sin_cos(input angle_t a, output longint c,
                                         output longint s);
        longint ang, x, y, z, dx, dy;
        int     i;
        ang = a;
        if (ang > ANGLE_PI)
            ang = ANGLE_PI;
        if (ang < -ANGLE_PI)
            ang = -ANGLE_PI;
        z = ang <<< 16;
        x = TRIG_GAIN;
        y = 0;
        for (i = 0; i < TRIG_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_Q30[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_Q30[i];
            end
        end
        c = x;
        s = y;
    endfunction

    // Product of two Q30 values, rounded back to Q30
    function automatic longint pair_q30(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // Q60 sum to Q1.14, rounded half up and held within +/-1
    function automatic result_t round_to_q14(longint v);
        longint r;
        r = (v + (64'sd1 <<< 45)) >>> 46;
        if (r > ONE_Q14)
            r = ONE_Q14;
        if (r < -ONE_Q14)
            r = -ONE_Q14;
        return result_t'(r);
    endfunction

    function automatic quat_t quat_from_euler(euler_t e);
        longint cr, sr, cp, sp, cy, sy;
        quat_t  q;
        half_sin_cos(e.roll, cr, sr);
        half_sin_cos(e.pitch, cp, sp);
        half_sin_cos(e.yaw, cy, sy);
        q.w = round_to_q14(pair_q30(cr, cp) * cy + pair_q30(sr, sp) * sy);
        q.x = round_to_q14(pair_q30(sr, cp) * cy - pair_q30(cr, sp) * sy);
        q.y = round_to_q14(pair_q30(cr, sp) * cy + pair_q30(sr, cp) * sy);
        q.z = round_to_q14(pair_q30(cr, cp) * sy - pair_q30(sr, sp) * cy);
        return q;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly in range, some raw codes beyond pi, some near zero and near the limits
    function automatic angle_t random_angle();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            return angle_t'(int'($urandom_range(51472)) - 25736);
        if (pick < 92)
            return angle_t'($urandom);
        if (pick < 96)
            return angle_t'(int'($urandom_range(16)) - 8);
        return angle_t'((pick[0] ? 25736 : -25736) + int'($urandom_range(6)) - 3);
    endfunction

    task automatic queue_angles(int r, int p, int y);
        euler_t e;
        e.roll  = angle_t'(r);
        e.pitch = angle_t'(p);
        e.yaw   = angle_t'(y);
        euler_q.insert(euler_q.size(), e);
    endtask

    function automatic void check_component(string label, result_t want, result_t got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
        end
    endfunction

    // Cycle count; reroll the quiet stretches periodically
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 300 == 0)
        begin
            in_quiet  <= ($urandom_range(3) == 0);
            out_quiet <= ($urandom_range(3) == 0);
        end
    end

    // Take an input word: predict its quaternion and count clamped inputs; else count input stalls
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            quat_expected.insert(quat_expected.size(), quat_from_euler(offered));
            accepted_count <= accepted_count + 1;
            if (offered.roll > ANGLE_PI || offered.roll < -ANGLE_PI ||
                offered.pitch > ANGLE_PI || offered.pitch < -ANGLE_PI ||
                offered.yaw > ANGLE_PI || offered.yaw < -ANGLE_PI)
                clamped_inputs <= clamped_inputs + 1;
            in_accepted <= 1'b1;
        end
        else
        begin
            if (rst_n && s_axis_tvalid)
                input_stalls <= input_stalls + 1;
            in_accepted <= 1'b0;
        end
    end

    // Driver: offer the next word once the current one is gone, after its gap
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_accepted))
        begin
            if (send_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end
            else if (euler_q.size() != 0)
            begin
                next_word     = euler_q.pop_front();
                offered       <= next_word;
                s_axis_tdata  <= next_word;
                s_axis_tvalid <= 1'b1;
                send_gap      <= in_quiet ? 0 : pick_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold to back the pipeline up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left     <= hold_left - 1;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done     <= 1'b1;
                hold_left     <= HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (ready_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                ready_gap     <= ready_gap - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                ready_gap     <= (out_quiet || $urandom_range(2) != 0) ? 0 : pick_gap();
            end
        end
    end

    // Monitor: compare each output word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen <= results_seen + 1;
            got_quat.w = m_axis_tdata[15:0];
            got_quat.x = m_axis_tdata[31:16];
            got_quat.y = m_axis_tdata[47:32];
            got_quat.z = m_axis_tdata[63:48];
            if (quat_expected.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected word, expected none, got w %0d x %0d y %0d z %0d",
                             $time, got_quat.w, got_quat.x, got_quat.y, got_quat.z);
            end
            else
            begin
                want_quat = quat_expected.pop_front();
                check_component("quat_w", want_quat.w, got_quat.w);
                check_component("quat_x", want_quat.x, got_quat.x);
                check_component("quat_y", want_quat.y, got_quat.y);
                check_component("quat_z", want_quat.z, got_quat.z);
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        // Directed: zero, pi and its limits, codes beyond pi, right angles, bit patterns
        queue_angles(0, 0, 0);
        queue_angles(25736, 0, 0);
        queue_angles(-25736, 0, 0);
        queue_angles(0, 25736, 0);
        queue_angles(0, -25736, 0);
        queue_angles(0, 0, 25736);
        queue_angles(0, 0, -25736);
        queue_angles(25736, 25736, 25736);
        queue_angles(-25736, -25736, -25736);
        queue_angles(32767, 32767, 32767);
        queue_angles(-32768, -32768, -32768);
        queue_angles(25737, -25737, 25737);
        queue_angles(-25737, 25737, -25737);
        queue_angles(12868, 12868, 12868);
        queue_angles(0, 12868, 0);
        queue_angles(0, -12868, 0);
        queue_angles(1, -1, 1);
        queue_angles('h5555, 'hAAAA, 'h5555);
        queue_angles('hAAAA, 'h5555, 'hAAAA);
        queue_angles('hFFFF, 0, 'h7FFF);
        for (n = 0; n < RAND_ITEMS; n++)
            queue_angles(random_angle(), random_angle(), random_angle());
        total_items = euler_q.size();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_items)
            @(posedge clk);
        while (quat_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d words, %0d with an angle clamped to pi, %0d input stall cycles",
                 accepted_count, clamped_inputs, input_stalls);
        $display("Output side held off for %0d cycles once, %0d mismatches",
                 HOLD_CYCLES, error_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Timeout
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("%0t: timeout with %0d words outstanding", $time, quat_expected.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/etq_pkg.sv
rtl/etq_cordic.sv
rtl/euler_to_quaternion.sv
tb/euler_to_quaternion_test.sv
